// File: hw/rtl/hsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and types of the hsl to rgb converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

  // width of every colour field on the ports
  localparam int FIELD_W = 8;

  // hsl scale: 240 is one full turn of hue and full saturation or lightness
  localparam int HSL_SCALE      = 240;
  localparam int HSL_HALF       = 120;
  localparam int HUE_THIRD      = 80;
  localparam int HUE_TWO_THIRDS = 160;
  localparam int HUE_SIXTH      = 40;

  // largest channel value
  localparam int CH_MAX = 255;

  // wrapped hue positions of the three channels
  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } hue_pos_t;

endpackage

// File: hw/rtl/hsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_if / rgb_if
// Valid/ready channels for hsl colours in and rgb pixels out.
// ----------------------------------------------------------------------------
interface hsl_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::FIELD_W-1:0]  hue;
  logic [hsl_pkg::FIELD_W-1:0]  saturation;
  logic [hsl_pkg::FIELD_W-1:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface rgb_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::FIELD_W-1:0]  red;
  logic [hsl_pkg::FIELD_W-1:0]  green;
  logic [hsl_pkg::FIELD_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: hw/rtl/hsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_front
// First stage: wraps hue, clamps saturation and lightness, converts them to
// fixed-point levels by table and forms the hue position of each channel.
// ----------------------------------------------------------------------------
module hsl_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [hsl_pkg::FIELD_W-1:0]       hue,
  input  logic [hsl_pkg::FIELD_W-1:0]       saturation,
  input  logic [hsl_pkg::FIELD_W-1:0]       lightness,
  output logic [FRAC_BITS:0]                lvl_l,
  output logic [FRAC_BITS:0]                lvl_s,
  output logic                              dark,
  output hsl_pkg::hue_pos_t                 pos
);

  localparam int LW = FRAC_BITS + 1;
  localparam int FW = hsl_pkg::FIELD_W;

  // floor(k * one / 240), evaluated at elaboration only
  function automatic logic [LW-1:0] scale_frac(input int unsigned k);
    scale_frac = LW'((64'(k) << FRAC_BITS) / hsl_pkg::HSL_SCALE);
  endfunction

  logic [LW-1:0] frac_tab [0:hsl_pkg::HSL_SCALE];

  for (genvar i = 0; i <= hsl_pkg::HSL_SCALE; i++) begin : g_tab
    assign frac_tab[i] = scale_frac(i);
  end

  logic [FW-1:0] hue_w;
  logic [FW-1:0] sat_c;
  logic [FW-1:0] lit_c;
  logic [FW:0]   red_sum;
  logic [FW:0]   blue_sum;
  logic [FW-1:0] red_pos;
  logic [FW-1:0] blue_pos;

  // wrap hue into one turn, saturate the other two
  always_comb begin
    hue_w = (hue >= FW'(hsl_pkg::HSL_SCALE)) ? hue - FW'(hsl_pkg::HSL_SCALE) : hue;
    sat_c = (saturation > FW'(hsl_pkg::HSL_SCALE)) ? FW'(hsl_pkg::HSL_SCALE) : saturation;
    lit_c = (lightness > FW'(hsl_pkg::HSL_SCALE)) ? FW'(hsl_pkg::HSL_SCALE) : lightness;
  end

  // channel positions: red a third ahead, blue two thirds ahead
  always_comb begin
    red_sum  = {1'b0, hue_w} + (FW + 1)'(hsl_pkg::HUE_THIRD);
    blue_sum = {1'b0, hue_w} + (FW + 1)'(hsl_pkg::HUE_TWO_THIRDS);
    red_pos  = (red_sum >= (FW + 1)'(hsl_pkg::HSL_SCALE))
             ? FW'(red_sum - (FW + 1)'(hsl_pkg::HSL_SCALE)) : FW'(red_sum);
    blue_pos = (blue_sum >= (FW + 1)'(hsl_pkg::HSL_SCALE))
             ? FW'(blue_sum - (FW + 1)'(hsl_pkg::HSL_SCALE)) : FW'(blue_sum);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      lvl_l     <= frac_tab[lit_c];
      lvl_s     <= frac_tab[sat_c];
      dark      <= (lit_c < FW'(hsl_pkg::HSL_HALF));
      pos.red   <= red_pos;
      pos.green <= hue_w;
      pos.blue  <= blue_pos;
    end
  end

endmodule

// File: hw/rtl/hsl_levels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_levels
// Second and third stages: product of lightness and saturation, then the two
// mixing levels v1 and v2 and their difference.
// ----------------------------------------------------------------------------
module hsl_levels #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [FRAC_BITS:0]  lvl_l,
  input  logic [FRAC_BITS:0]  lvl_s,
  input  logic                dark,
  output logic [FRAC_BITS+1:0] v1,
  output logic [FRAC_BITS+1:0] v2,
  output logic [FRAC_BITS+1:0] diff
);

  localparam int LW = FRAC_BITS + 1;
  localparam int VW = FRAC_BITS + 2;

  logic [2*LW-1:0] prod;
  logic [LW-1:0]   ls;
  logic [LW-1:0]   l_s2;
  logic [LW-1:0]   s_s2;
  logic            dark_s2;

  // stage two: product of the two levels
  assign prod = lvl_l * lvl_s;

  always_ff @(posedge clk) begin
    if (en) begin
      ls      <= prod[FRAC_BITS +: LW];
      l_s2    <= lvl_l;
      s_s2    <= lvl_s;
      dark_s2 <= dark;
    end
  end

  logic [VW-1:0] mix_sum;
  logic [VW-1:0] two_l;
  logic [VW-1:0] v2_c;
  logic [VW-1:0] v1_c;

  // stage three: mixing levels, v2 held to at most twice lightness
  always_comb begin
    two_l = {l_s2, 1'b0};
    if (dark_s2) begin
      mix_sum = VW'(l_s2) + VW'(ls);
    end else begin
      mix_sum = VW'(l_s2) + VW'(s_s2) - VW'(ls);
    end
    v2_c = (mix_sum > two_l) ? two_l : mix_sum;
    v1_c = two_l - v2_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= v1_c;
      v2   <= v2_c;
      diff <= v2_c - v1_c;
    end
  end

endmodule

// File: hw/rtl/hsl_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_chan
// One colour channel: piecewise-linear hue function over stages two to
// five, then scaling of the level to an 8-bit intensity in stage six.
// ----------------------------------------------------------------------------
module hsl_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hsl_pkg::FIELD_W-1:0]  pos,
  input  logic [FRAC_BITS+1:0]         v1,
  input  logic [FRAC_BITS+1:0]         v2,
  input  logic [FRAC_BITS+1:0]         diff,
  output logic [hsl_pkg::FIELD_W-1:0]  ch
);

  localparam int LW = FRAC_BITS + 1;
  localparam int VW = FRAC_BITS + 2;
  localparam int FW = hsl_pkg::FIELD_W;
  localparam int KW = $clog2(hsl_pkg::HUE_SIXTH + 1);
  localparam int XW = VW + 8;

  // segments of the hue function
  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  // floor(k * one / 40), evaluated at elaboration only
  function automatic logic [LW-1:0] ramp_frac(input int unsigned k);
    ramp_frac = LW'((64'(k) << FRAC_BITS) / hsl_pkg::HUE_SIXTH);
  endfunction

  logic [LW-1:0] ramp_tab [0:hsl_pkg::HUE_SIXTH];

  for (genvar i = 0; i <= hsl_pkg::HUE_SIXTH; i++) begin : g_tab
    assign ramp_tab[i] = ramp_frac(i);
  end

  // stage two: position waits for the mixing levels
  logic [FW-1:0] pos_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_s2 <= pos;
    end
  end

  // stage three: segment and ramp fraction from the position
  logic [1:0]    seg_c;
  logic [KW-1:0] k_c;
  logic [FW-1:0] fall_k;

  always_comb begin
    fall_k = FW'(hsl_pkg::HUE_TWO_THIRDS) - pos_s2;
    if (pos_s2 < FW'(hsl_pkg::HUE_SIXTH)) begin
      seg_c = SEG_RISE;
      k_c   = pos_s2[KW-1:0];
    end else if (pos_s2 < FW'(hsl_pkg::HSL_HALF)) begin
      seg_c = SEG_HIGH;
      k_c   = '0;
    end else if (pos_s2 < FW'(hsl_pkg::HUE_TWO_THIRDS)) begin
      seg_c = SEG_FALL;
      k_c   = fall_k[KW-1:0];
    end else begin
      seg_c = SEG_LOW;
      k_c   = '0;
    end
  end

  logic [1:0]    seg_s3;
  logic [LW-1:0] frac_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      seg_s3  <= seg_c;
      frac_s3 <= ramp_tab[k_c];
    end
  end

  // stage four: scaled ramp
  logic [VW+LW-1:0] ramp_prod;
  logic [VW-1:0]    ramp_s4;
  logic [VW-1:0]    v1_s4;
  logic [VW-1:0]    v2_s4;
  logic [1:0]       seg_s4;

  assign ramp_prod = diff * frac_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      ramp_s4 <= ramp_prod[FRAC_BITS +: VW];
      v1_s4   <= v1;
      v2_s4   <= v2;
      seg_s4  <= seg_s3;
    end
  end

  // stage five: level of this channel
  logic [VW-1:0] level_c;
  logic [VW-1:0] level_s5;

  always_comb begin
    case (seg_s4)
      SEG_RISE, SEG_FALL: level_c = v1_s4 + ramp_s4;
      SEG_HIGH:           level_c = v2_s4;
      SEG_LOW:            level_c = v1_s4;
      default:            level_c = v1_s4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_s5 <= level_c;
    end
  end

  // stage six: times 255, truncate and clamp
  logic [XW-1:0]     scaled;
  logic [XW-FRAC_BITS-1:0] whole;

  always_comb begin
    scaled = {level_s5, 8'd0} - XW'(level_s5);
    whole  = scaled[XW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch <= (whole > (XW - FRAC_BITS)'(hsl_pkg::CH_MAX))
          ? FW'(hsl_pkg::CH_MAX) : whole[FW-1:0];
    end
  end

endmodule

// File: hw/rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Six-stage pipeline turning hsl colours (0..240 scale) into rgb pixels.
// ----------------------------------------------------------------------------
//  channel | dir | payload                           | handshake
//  --------+-----+-----------------------------------+-------------
//  hsl     | in  | hue, saturation, lightness (8 b)  | valid/ready
//  rgb     | out | red, green, blue (8 b)            | valid/ready
//
// one transaction accepted per clock unless rgb stalls; each pixel passes in
// order through the six register stages
// (lookup, product, mixing levels, ramp product, level, channel scale).
// rst clears the stage valid bits only; the data path carries no reset.
// a stall on rgb freezes every stage together; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  hsl_if.sink      hsl,
  rgb_if.source    rgb
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic              en;

  // whole pipeline advances unless the output holds an untaken pixel
  assign en        = !vld[STAGES-1] || rgb.ready;
  assign hsl.ready = en;
  assign rgb.valid = vld[STAGES-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], hsl.valid};
    end
  end

  logic [FRAC_BITS:0]   lvl_l;
  logic [FRAC_BITS:0]   lvl_s;
  logic                 dark;
  hsl_pkg::hue_pos_t    pos;
  logic [FRAC_BITS+1:0] v1;
  logic [FRAC_BITS+1:0] v2;
  logic [FRAC_BITS+1:0] diff;

  // stage one
  hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (en),
    .hue        (hsl.hue),
    .saturation (hsl.saturation),
    .lightness  (hsl.lightness),
    .lvl_l      (lvl_l),
    .lvl_s      (lvl_s),
    .dark       (dark),
    .pos        (pos)
  );

  // stages two and three
  hsl_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
    .clk   (clk),
    .en    (en),
    .lvl_l (lvl_l),
    .lvl_s (lvl_s),
    .dark  (dark),
    .v1    (v1),
    .v2    (v2),
    .diff  (diff)
  );

  // stages two to six, one per channel
  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk  (clk),
    .en   (en),
    .pos  (pos.red),
    .v1   (v1),
    .v2   (v2),
    .diff (diff),
    .ch   (rgb.red)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk  (clk),
    .en   (en),
    .pos  (pos.green),
    .v1   (v1),
    .v2   (v2),
    .diff (diff),
    .ch   (rgb.green)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk  (clk),
    .en   (en),
    .pos  (pos.blue),
    .v1   (v1),
    .v2   (v2),
    .diff (diff),
    .ch   (rgb.blue)
  );

`ifndef SYNTHESIS
  // an accepted colour enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    en |=> (vld[0] == $past(hsl.valid)))
    else $error("first stage valid does not follow the accepted input");

  // a stall freezes every stage
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // the last internal stage reaches the output when the pipeline advances
  a_reach: assert property (@(posedge clk) disable iff (rst)
    (en && vld[STAGES-2]) |=> rgb.valid)
    else $error("pixel dropped before the output");
`endif

endmodule
